// ===== hdl/etfp_pkg.sv =====
`default_nettype none

package etfp_pkg;

    // Field and register widths fixed by the item format.
    localparam int C_IN_W     = 32;
    localparam int Z_W        = 33;
    localparam int Q30_W      = 31;
    localparam int SQ_W       = 62;
    localparam int ACC_W      = 124;
    localparam int Y2_SHIFT   = 58;
    localparam int CH_W       = 8;
    localparam int MAXI_W     = 16;
    localparam int LIM_W      = 31;
    localparam int BAND_W     = 8;
    localparam int OFF_W      = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC_LIMIT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_W    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_OFF  = 8'd3;

    localparam logic [MAXI_W-1:0] RST_MAX_ITER  = 16'd1024;
    localparam logic [LIM_W-1:0]  RST_ESC_LIMIT = 31'd671088640;
    localparam logic [BAND_W-1:0] RST_BAND_W    = 8'd28;
    localparam logic [OFF_W-1:0]  RST_BAND_OFF  = 16'd136;

    localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [31:0]     BLACK_PIXEL  = 32'hFF00_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CPREP,
        ST_CQA,
        ST_CQY,
        ST_CS,
        ST_CMUL,
        ST_CCMP,
        ST_ICHK,
        ST_MXX,
        ST_MYY,
        ST_MXY,
        ST_UPD,
        ST_DIV,
        ST_DIVEND,
        ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        PH_SEG,
        PH_RED,
        PH_GRN,
        PH_BLU
    } t_phase;

    typedef enum logic [1:0] {
        CH_RED,
        CH_GRN,
        CH_BLU
    } t_chan;

    // One palette term: channel = base +/- slope * t / w.
    typedef struct packed {
        logic [CH_W-1:0] base;
        logic [CH_W-1:0] slope;
        logic            sub;
    } t_pal;

    function automatic t_pal pal_lookup(input logic [1:0] seg, input t_chan ch);
        t_pal e;
        e = '{base: 8'd0, slope: 8'd0, sub: 1'b0};
        case (seg)
            2'd0: begin
                case (ch)
                    CH_RED:  e = '{base: 8'd0,   slope: 8'd237, sub: 1'b0};
                    CH_GRN:  e = '{base: 8'd11,  slope: 8'd244, sub: 1'b0};
                    CH_BLU:  e = '{base: 8'd116, slope: 8'd139, sub: 1'b0};
                    default: e = '{base: 8'd0,   slope: 8'd0,   sub: 1'b0};
                endcase
            end
            2'd1: begin
                case (ch)
                    CH_RED:  e = '{base: 8'd238, slope: 8'd0,   sub: 1'b0};
                    CH_GRN:  e = '{base: 8'd255, slope: 8'd123, sub: 1'b1};
                    CH_BLU:  e = '{base: 8'd255, slope: 8'd253, sub: 1'b1};
                    default: e = '{base: 8'd0,   slope: 8'd0,   sub: 1'b0};
                endcase
            end
            2'd2: begin
                case (ch)
                    CH_RED:  e = '{base: 8'd239, slope: 8'd239, sub: 1'b1};
                    CH_GRN:  e = '{base: 8'd132, slope: 8'd121, sub: 1'b1};
                    CH_BLU:  e = '{base: 8'd2,   slope: 8'd114, sub: 1'b0};
                    default: e = '{base: 8'd0,   slope: 8'd0,   sub: 1'b0};
                endcase
            end
            default: e = '{base: 8'd0, slope: 8'd0, sub: 1'b0};
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/escape_time_fractal_pixel_core.sv =====
`default_nettype none

// Mandelbrot escape-time pixel core. Each input transfer carries one point c
// in signed fixed point with FRAC_BITS fractional bits; each output transfer
// carries its packed colour, its escape count and an inside-set flag. One
// point is worked at a time and the input is not ready meanwhile. All
// products go through a single shared 32x32 multiplier: the main-cardioid
// test is two squarings, four partial products of a 62x62 product and a
// compare, a point outside the cardioid's range check skips it, and every
// z = z^2 + c iteration is three products and an update. An escaped point
// then gets its colour from a restoring divider that produces one quotient
// bit per cycle: four divisions of max(COUNT_WIDTH,16)+1 steps each. A
// finished result waits in an output register, so the next point is taken
// while the previous result is still waiting.
module escape_time_fractal_pixel_core #(
    parameter int FRAC_BITS   = 26,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // s_axis_tdata: [31:0] c_real, [63:32] c_imag
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    input  wire logic [63:0]                            s_axis_tdata,
    // m_axis_tdata: [31:0] pixel_color, [32+COUNT_WIDTH-1:32] iteration_count,
    // zero padding above
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    output logic [((32+COUNT_WIDTH+7)/8)*8-1:0]         m_axis_tdata,
    // m_axis_tuser: [0] inside_set
    output logic [0:0]                                  m_axis_tuser,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [etfp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [etfp_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int P_W    = 64 - FRAC_BITS;
    localparam int SUM_W  = (P_W + 1 > etfp_pkg::LIM_W) ? P_W + 1 : etfp_pkg::LIM_W;
    localparam int E_W    = (P_W > 32) ? P_W : 32;
    localparam int A_W    = ((FRAC_BITS > 30) ? FRAC_BITS : 31) + 3;
    localparam int SH_R   = (FRAC_BITS >= 30) ? FRAC_BITS - 30 : 0;
    localparam int SH_L   = (FRAC_BITS < 30) ? 30 - FRAC_BITS : 0;
    localparam int CAP_W  = (COUNT_WIDTH < etfp_pkg::MAXI_W) ? COUNT_WIDTH : etfp_pkg::MAXI_W;
    localparam int DV_W   = ((COUNT_WIDTH > etfp_pkg::OFF_W) ? COUNT_WIDTH
                                                             : etfp_pkg::OFF_W) + 1;
    localparam int DCNT_W = $clog2(DV_W);
    localparam int OUT_W  = ((32 + COUNT_WIDTH + 7) / 8) * 8;

    localparam logic signed [A_W-1:0] ONE_FX     = (A_W)'(1) << FRAC_BITS;
    localparam logic signed [A_W-1:0] QUARTER_FX = ONE_FX >>> 2;

    // Control and configuration registers.
    etfp_pkg::t_state                 r_state, n_state;
    logic                             r_ovalid, n_ovalid;
    logic [etfp_pkg::MAXI_W-1:0]      r_max_iter, n_max_iter;
    logic [etfp_pkg::LIM_W-1:0]       r_limit, n_limit;
    logic [etfp_pkg::BAND_W-1:0]      r_band_w, n_band_w;
    logic [etfp_pkg::OFF_W-1:0]       r_band_off, n_band_off;

    // Datapath registers.
    logic signed [31:0]               r_cr, n_cr;
    logic signed [31:0]               r_ci, n_ci;
    logic signed [etfp_pkg::Z_W-1:0]  r_zx, n_zx;
    logic signed [etfp_pkg::Z_W-1:0]  r_zy, n_zy;
    logic [COUNT_WIDTH-1:0]           r_n, n_n;
    logic [P_W-1:0]                   r_p1, n_p1;
    logic [P_W-1:0]                   r_p2, n_p2;
    logic [P_W-1:0]                   r_p3, n_p3;
    logic                             r_esc, n_esc;
    logic [etfp_pkg::Q30_W-1:0]       r_m_a, n_m_a;
    logic [etfp_pkg::Q30_W-1:0]       r_m_y, n_m_y;
    logic                             r_a_neg, n_a_neg;
    logic [etfp_pkg::SQ_W-1:0]        r_qa, n_qa;
    logic [etfp_pkg::SQ_W-1:0]        r_y2c, n_y2c;
    logic [etfp_pkg::SQ_W-1:0]        r_q, n_q;
    logic [etfp_pkg::SQ_W-1:0]        r_s, n_s;
    logic [etfp_pkg::ACC_W-1:0]       r_acc, n_acc;
    logic [1:0]                       r_k, n_k;
    logic                             r_inside, n_inside;
    logic [DV_W-1:0]                  r_dvd, n_dvd;
    logic [DV_W-1:0]                  r_quo, n_quo;
    logic [etfp_pkg::BAND_W-1:0]      r_rem, n_rem;
    logic [1:0]                       r_qm3, n_qm3;
    logic [DCNT_W-1:0]                r_dcnt, n_dcnt;
    etfp_pkg::t_phase                 r_phase, n_phase;
    logic [1:0]                       r_seg, n_seg;
    logic [etfp_pkg::BAND_W-1:0]      r_t, n_t;
    logic [etfp_pkg::CH_W-1:0]        r_red, n_red;
    logic [etfp_pkg::CH_W-1:0]        r_grn, n_grn;
    logic [etfp_pkg::CH_W-1:0]        r_blu, n_blu;
    logic [31:0]                      r_opix, n_opix;
    logic [COUNT_WIDTH-1:0]           r_ocnt, n_ocnt;
    logic                             r_oinside, n_oinside;

    // Shared multiplier.
    logic [31:0]                      mul_a, mul_b;
    logic [63:0]                      mul_p;

    // Combinational helpers.
    logic [COUNT_WIDTH-1:0]           cap;
    logic [COUNT_WIDTH-1:0]           n_plus;
    logic [etfp_pkg::Z_W-1:0]         zx_abs, zy_abs;
    logic [31:0]                      mx, my;
    logic [SUM_W-1:0]                 r2_sum;
    logic signed [E_W+1:0]            zx_w;
    logic signed [E_W+2:0]            xy_dbl, zy_w;
    logic signed [A_W-1:0]            a_w, y_w;
    logic [A_W-1:0]                   a_abs, y_abs;
    logic                             card_out;
    logic [etfp_pkg::SQ_W-1:0]        q_sum;
    logic [etfp_pkg::SQ_W:0]          ma_sh, s_w;
    logic [1:0]                       k_sum;
    logic [etfp_pkg::ACC_W-1:0]       pp_sh;
    logic [etfp_pkg::BAND_W-1:0]      w_eff;
    logic [etfp_pkg::BAND_W:0]        trial;
    logic                             ge;
    logic [etfp_pkg::BAND_W-1:0]      rem_step;
    logic [1:0]                       qm3_step;
    logic [1:0]                       seg_sel;
    logic [etfp_pkg::BAND_W-1:0]      t_sel;
    etfp_pkg::t_chan                  ch_next, ch_cur;
    etfp_pkg::t_pal                   pal_next, pal_cur;
    logic [etfp_pkg::CH_W-1:0]        chan_val;

    assign mul_p = mul_a * mul_b;

    assign s_axis_tready = (r_state == etfp_pkg::ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = OUT_W'({r_ocnt, r_opix});
    assign m_axis_tuser  = r_oinside;

    always_comb begin
        cap    = COUNT_WIDTH'(r_max_iter[CAP_W-1:0]);
        n_plus = r_n + COUNT_WIDTH'(1);

        zx_abs = r_zx[etfp_pkg::Z_W-1] ? etfp_pkg::Z_W'(-r_zx) : etfp_pkg::Z_W'(r_zx);
        zy_abs = r_zy[etfp_pkg::Z_W-1] ? etfp_pkg::Z_W'(-r_zy) : etfp_pkg::Z_W'(r_zy);
        mx     = zx_abs[31:0];
        my     = zy_abs[31:0];

        r2_sum = SUM_W'(r_p1) + SUM_W'(r_p2);
        zx_w   = $signed({2'b00, E_W'(r_p1)}) - $signed({2'b00, E_W'(r_p2)})
                 + (E_W+2)'(r_cr);
        xy_dbl = $signed({2'b00, E_W'(r_p3), 1'b0});
        zy_w   = ((r_zx[etfp_pkg::Z_W-1] ^ r_zy[etfp_pkg::Z_W-1]) ? -xy_dbl : xy_dbl)
                 + (E_W+3)'(r_ci);

        // Cardioid range check and conversion to 30 fractional bits.
        a_w      = (A_W)'(r_cr) - QUARTER_FX;
        y_w      = (A_W)'(r_ci);
        card_out = (a_w > ONE_FX) || (a_w < -ONE_FX) || (y_w > ONE_FX) || (y_w < -ONE_FX);
        a_abs    = a_w[A_W-1] ? A_W'(-a_w) : A_W'(a_w);
        y_abs    = y_w[A_W-1] ? A_W'(-y_w) : A_W'(y_w);

        q_sum = r_qa + r_y2c;
        ma_sh = {2'b00, r_m_a, 30'd0};
        s_w   = r_a_neg ? ({1'b0, q_sum} - ma_sh) : ({1'b0, q_sum} + ma_sh);
        k_sum = {1'b0, r_k[0]} + {1'b0, r_k[1]};
        pp_sh = etfp_pkg::ACC_W'(mul_p) << {k_sum, 5'd0};

        // Restoring divider step, tracking the quotient modulo three.
        w_eff    = (r_band_w == '0) ? etfp_pkg::BAND_W'(1) : r_band_w;
        trial    = {r_rem, r_dvd[DV_W-1]};
        ge       = (trial >= {1'b0, w_eff});
        rem_step = ge ? etfp_pkg::BAND_W'(trial - {1'b0, w_eff}) : trial[etfp_pkg::BAND_W-1:0];
        case ({r_qm3, ge})
            3'b000:  qm3_step = 2'd0;
            3'b001:  qm3_step = 2'd1;
            3'b010:  qm3_step = 2'd2;
            3'b011:  qm3_step = 2'd0;
            3'b100:  qm3_step = 2'd1;
            3'b101:  qm3_step = 2'd2;
            default: qm3_step = 2'd0;
        endcase

        seg_sel = (r_phase == etfp_pkg::PH_SEG) ? r_qm3 : r_seg;
        t_sel   = (r_phase == etfp_pkg::PH_SEG) ? r_rem : r_t;
        case (r_phase)
            etfp_pkg::PH_SEG: begin
                ch_next = etfp_pkg::CH_RED;
                ch_cur  = etfp_pkg::CH_RED;
            end
            etfp_pkg::PH_RED: begin
                ch_next = etfp_pkg::CH_GRN;
                ch_cur  = etfp_pkg::CH_RED;
            end
            etfp_pkg::PH_GRN: begin
                ch_next = etfp_pkg::CH_BLU;
                ch_cur  = etfp_pkg::CH_GRN;
            end
            default: begin
                ch_next = etfp_pkg::CH_BLU;
                ch_cur  = etfp_pkg::CH_BLU;
            end
        endcase
        pal_next = etfp_pkg::pal_lookup(seg_sel, ch_next);
        pal_cur  = etfp_pkg::pal_lookup(r_seg, ch_cur);
        chan_val = pal_cur.sub ? (pal_cur.base - r_quo[etfp_pkg::CH_W-1:0])
                               : (pal_cur.base + r_quo[etfp_pkg::CH_W-1:0]);
    end

    always_comb begin
        n_state    = r_state;
        n_ovalid   = r_ovalid;
        n_max_iter = r_max_iter;
        n_limit    = r_limit;
        n_band_w   = r_band_w;
        n_band_off = r_band_off;
        n_cr       = r_cr;
        n_ci       = r_ci;
        n_zx       = r_zx;
        n_zy       = r_zy;
        n_n        = r_n;
        n_p1       = r_p1;
        n_p2       = r_p2;
        n_p3       = r_p3;
        n_esc      = r_esc;
        n_m_a      = r_m_a;
        n_m_y      = r_m_y;
        n_a_neg    = r_a_neg;
        n_qa       = r_qa;
        n_y2c      = r_y2c;
        n_q        = r_q;
        n_s        = r_s;
        n_acc      = r_acc;
        n_k        = r_k;
        n_inside   = r_inside;
        n_dvd      = r_dvd;
        n_quo      = r_quo;
        n_rem      = r_rem;
        n_qm3      = r_qm3;
        n_dcnt     = r_dcnt;
        n_phase    = r_phase;
        n_seg      = r_seg;
        n_t        = r_t;
        n_red      = r_red;
        n_grn      = r_grn;
        n_blu      = r_blu;
        n_opix     = r_opix;
        n_ocnt     = r_ocnt;
        n_oinside  = r_oinside;
        mul_a      = '0;
        mul_b      = '0;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                etfp_pkg::CFG_MAX_ITER:  n_max_iter = i_cfg_data[etfp_pkg::MAXI_W-1:0];
                etfp_pkg::CFG_ESC_LIMIT: n_limit    = i_cfg_data[etfp_pkg::LIM_W-1:0];
                etfp_pkg::CFG_BAND_W:    n_band_w   = i_cfg_data[etfp_pkg::BAND_W-1:0];
                etfp_pkg::CFG_BAND_OFF:  n_band_off = i_cfg_data[etfp_pkg::OFF_W-1:0];
                default: ;
            endcase
        end

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            etfp_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cr    = $signed(s_axis_tdata[31:0]);
                    n_ci    = $signed(s_axis_tdata[63:32]);
                    n_zx    = etfp_pkg::Z_W'($signed(s_axis_tdata[31:0]));
                    n_zy    = etfp_pkg::Z_W'($signed(s_axis_tdata[63:32]));
                    n_n     = '0;
                    n_state = etfp_pkg::ST_CPREP;
                end
            end
            etfp_pkg::ST_CPREP: begin
                n_m_a   = etfp_pkg::Q30_W'((a_abs >> SH_R) << SH_L);
                n_m_y   = etfp_pkg::Q30_W'((y_abs >> SH_R) << SH_L);
                n_a_neg = a_w[A_W-1];
                n_state = card_out ? etfp_pkg::ST_ICHK : etfp_pkg::ST_CQA;
            end
            etfp_pkg::ST_CQA: begin
                mul_a   = {1'b0, r_m_a};
                mul_b   = {1'b0, r_m_a};
                n_qa    = mul_p[etfp_pkg::SQ_W-1:0];
                n_state = etfp_pkg::ST_CQY;
            end
            etfp_pkg::ST_CQY: begin
                mul_a   = {1'b0, r_m_y};
                mul_b   = {1'b0, r_m_y};
                n_y2c   = mul_p[etfp_pkg::SQ_W-1:0];
                n_state = etfp_pkg::ST_CS;
            end
            etfp_pkg::ST_CS: begin
                // A non-positive second factor puts the point inside at once.
                if (s_w[etfp_pkg::SQ_W] || (s_w == '0)) begin
                    n_n      = cap;
                    n_inside = 1'b1;
                    n_state  = etfp_pkg::ST_FIN;
                end else begin
                    n_q     = q_sum;
                    n_s     = s_w[etfp_pkg::SQ_W-1:0];
                    n_acc   = '0;
                    n_k     = '0;
                    n_state = etfp_pkg::ST_CMUL;
                end
            end
            etfp_pkg::ST_CMUL: begin
                mul_a   = r_k[0] ? {2'b00, r_q[etfp_pkg::SQ_W-1:32]} : r_q[31:0];
                mul_b   = r_k[1] ? {2'b00, r_s[etfp_pkg::SQ_W-1:32]} : r_s[31:0];
                n_acc   = r_acc + pp_sh;
                n_k     = r_k + 2'd1;
                if (r_k == 2'd3) begin
                    n_state = etfp_pkg::ST_CCMP;
                end
            end
            etfp_pkg::ST_CCMP: begin
                if (r_acc <= (etfp_pkg::ACC_W'(r_y2c) << etfp_pkg::Y2_SHIFT)) begin
                    n_n      = cap;
                    n_inside = 1'b1;
                    n_state  = etfp_pkg::ST_FIN;
                end else begin
                    n_state = etfp_pkg::ST_ICHK;
                end
            end
            etfp_pkg::ST_ICHK: begin
                if (r_n >= cap) begin
                    n_inside = 1'b1;
                    n_state  = etfp_pkg::ST_FIN;
                end else begin
                    n_state = etfp_pkg::ST_MXX;
                end
            end
            etfp_pkg::ST_MXX: begin
                mul_a   = mx;
                mul_b   = mx;
                n_p1    = mul_p[63:FRAC_BITS];
                n_state = etfp_pkg::ST_MYY;
            end
            etfp_pkg::ST_MYY: begin
                mul_a   = my;
                mul_b   = my;
                n_p2    = mul_p[63:FRAC_BITS];
                n_state = etfp_pkg::ST_MXY;
            end
            etfp_pkg::ST_MXY: begin
                mul_a   = mx;
                mul_b   = my;
                n_p3    = mul_p[63:FRAC_BITS];
                n_esc   = (r2_sum >= SUM_W'(r_limit));
                n_state = etfp_pkg::ST_UPD;
            end
            etfp_pkg::ST_UPD: begin
                if (r_esc) begin
                    n_inside = 1'b0;
                    n_dvd    = DV_W'(r_n) + DV_W'(r_band_off);
                    n_rem    = '0;
                    n_quo    = '0;
                    n_qm3    = '0;
                    n_dcnt   = DCNT_W'(DV_W - 1);
                    n_phase  = etfp_pkg::PH_SEG;
                    n_state  = etfp_pkg::ST_DIV;
                end else begin
                    n_zx = zx_w[etfp_pkg::Z_W-1:0];
                    n_zy = zy_w[etfp_pkg::Z_W-1:0];
                    n_n  = n_plus;
                    if (n_plus >= cap) begin
                        n_inside = 1'b1;
                        n_state  = etfp_pkg::ST_FIN;
                    end else begin
                        n_state = etfp_pkg::ST_MXX;
                    end
                end
            end
            etfp_pkg::ST_DIV: begin
                n_rem = rem_step;
                n_qm3 = qm3_step;
                n_quo = {r_quo[DV_W-2:0], ge};
                n_dvd = r_dvd << 1;
                if (r_dcnt == '0) begin
                    n_state = etfp_pkg::ST_DIVEND;
                end else begin
                    n_dcnt = r_dcnt - DCNT_W'(1);
                end
            end
            etfp_pkg::ST_DIVEND: begin
                // The next palette term's slope times t goes straight into the divider.
                mul_a  = {24'd0, pal_next.slope};
                mul_b  = {24'd0, t_sel};
                n_dvd  = DV_W'(mul_p[15:0]);
                n_rem  = '0;
                n_quo  = '0;
                n_qm3  = '0;
                n_dcnt = DCNT_W'(DV_W - 1);
                case (r_phase)
                    etfp_pkg::PH_SEG: begin
                        n_seg   = r_qm3;
                        n_t     = r_rem;
                        n_phase = etfp_pkg::PH_RED;
                        n_state = etfp_pkg::ST_DIV;
                    end
                    etfp_pkg::PH_RED: begin
                        n_red   = chan_val;
                        n_phase = etfp_pkg::PH_GRN;
                        n_state = etfp_pkg::ST_DIV;
                    end
                    etfp_pkg::PH_GRN: begin
                        n_grn   = chan_val;
                        n_phase = etfp_pkg::PH_BLU;
                        n_state = etfp_pkg::ST_DIV;
                    end
                    default: begin
                        n_blu   = chan_val;
                        n_state = etfp_pkg::ST_FIN;
                    end
                endcase
            end
            etfp_pkg::ST_FIN: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid  = 1'b1;
                    n_opix    = r_inside ? etfp_pkg::BLACK_PIXEL
                                         : {etfp_pkg::ALPHA_OPAQUE, r_blu, r_grn, r_red};
                    n_ocnt    = r_n;
                    n_oinside = r_inside;
                    n_state   = etfp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = etfp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= etfp_pkg::ST_IDLE;
            r_ovalid   <= 1'b0;
            r_max_iter <= etfp_pkg::RST_MAX_ITER;
            r_limit    <= etfp_pkg::RST_ESC_LIMIT;
            r_band_w   <= etfp_pkg::RST_BAND_W;
            r_band_off <= etfp_pkg::RST_BAND_OFF;
        end else begin
            r_state    <= n_state;
            r_ovalid   <= n_ovalid;
            r_max_iter <= n_max_iter;
            r_limit    <= n_limit;
            r_band_w   <= n_band_w;
            r_band_off <= n_band_off;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cr      <= n_cr;
        r_ci      <= n_ci;
        r_zx      <= n_zx;
        r_zy      <= n_zy;
        r_n       <= n_n;
        r_p1      <= n_p1;
        r_p2      <= n_p2;
        r_p3      <= n_p3;
        r_esc     <= n_esc;
        r_m_a     <= n_m_a;
        r_m_y     <= n_m_y;
        r_a_neg   <= n_a_neg;
        r_qa      <= n_qa;
        r_y2c     <= n_y2c;
        r_q       <= n_q;
        r_s       <= n_s;
        r_acc     <= n_acc;
        r_k       <= n_k;
        r_inside  <= n_inside;
        r_dvd     <= n_dvd;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_qm3     <= n_qm3;
        r_dcnt    <= n_dcnt;
        r_phase   <= n_phase;
        r_seg     <= n_seg;
        r_t       <= n_t;
        r_red     <= n_red;
        r_grn     <= n_grn;
        r_blu     <= n_blu;
        r_opix    <= n_opix;
        r_ocnt    <= n_ocnt;
        r_oinside <= n_oinside;
    end

endmodule

`default_nettype wire

// ===== hdl/etfp_checker.sv =====
`default_nettype none

module etfp_checker #(
    parameter int COUNT_WIDTH = 16
) (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               s_axis_tvalid,
    input wire logic                               s_axis_tready,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [((32+COUNT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    input wire logic [0:0]                         m_axis_tuser
);

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // A result that is not taken stays as it is.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // One point at a time: the input closes right after a transfer.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transfer");

    // A point inside the set is shown opaque black.
    a_inside_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[31:0] == etfp_pkg::BLACK_PIXEL)
        else $error("inside point not black");

    // Every colour is opaque.
    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[31:24] == etfp_pkg::ALPHA_OPAQUE)
        else $error("pixel alpha not opaque");

endmodule

bind escape_time_fractal_pixel_core etfp_checker #(
    .COUNT_WIDTH(COUNT_WIDTH)
) u_etfp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
